// ----- hdl/wti_pkg.sv -----
// ============================================================================
// wti_pkg
// Shared types and constants for the wavetable oscillator with interpolation.
// ============================================================================
package wti_pkg;

    localparam int FREQ_BITS     = 24;
    localparam int SIZE_BITS     = 4;
    localparam int CFG_DATA_BITS = 32;
    // product of freq and step_scale is scaled down to a 2^48 full turn
    localparam int SCALE_REF     = 48;
    localparam int SCALE_PROD_BITS = FREQ_BITS + CFG_DATA_BITS;

    localparam logic [SIZE_BITS-1:0]     SIZE_LOG2_RESET  = 4'd10;
    localparam logic [CFG_DATA_BITS-1:0] STEP_SCALE_RESET = 32'd24932236;

    typedef enum logic [0:0] {
        CFG_SIZE_LOG2  = 1'b0,
        CFG_STEP_SCALE = 1'b1
    } cfg_index_t;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef struct packed {
        logic  valid;
        func_t func;
    } stage_ctl_t;

endpackage

// ----- hdl/wti_ram.sv -----
// ============================================================================
// wti_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module wti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/wti_phase.sv -----
// ============================================================================
// wti_phase
// Increment multiply, phase accumulator, table address generation and
// table write port.
// ============================================================================
module wti_phase
    import wti_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_BITS      = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  func_t                         in_func,
    input  logic [FREQ_BITS-1:0]          in_freq,
    input  logic [TABLE_ADDR_BITS-1:0]    in_addr,
    input  logic [SAMPLE_BITS-1:0]        in_data,
    input  logic [SIZE_BITS-1:0]          size_log2,
    input  logic [CFG_DATA_BITS-1:0]      step_scale,
    output logic                          ram_we,
    output logic [TABLE_ADDR_BITS-1:0]    ram_waddr,
    output logic [SAMPLE_BITS-1:0]        ram_wdata,
    output logic                          ram_re,
    output logic [TABLE_ADDR_BITS-1:0]    rd_addr0,
    output logic [TABLE_ADDR_BITS-1:0]    rd_addr1,
    output stage_ctl_t                    s2_ctl,
    output logic [PHASE_BITS-2:0]         s2_frac,
    output logic [$clog2(PHASE_BITS)-1:0] s2_lobits
);

    localparam int LW  = $clog2(PHASE_BITS);
    localparam int SLW = $clog2(TABLE_ADDR_BITS + 1);

    stage_ctl_t                   s1_ctl_reg;
    logic [PHASE_BITS-1:0]        s1_inc_reg;
    logic [TABLE_ADDR_BITS-1:0]   s1_addr_reg;
    logic [SAMPLE_BITS-1:0]       s1_data_reg;
    logic [PHASE_BITS-1:0]        phase_reg;
    logic [PHASE_BITS-1:0]        phase_next;
    stage_ctl_t                   s2_ctl_reg;
    logic [PHASE_BITS-2:0]        s2_frac_reg;
    logic [LW-1:0]                s2_lobits_reg;

    logic [SCALE_PROD_BITS-1:0]   scale_prod;
    logic [SLW-1:0]               sl;
    logic [LW-1:0]                lobits;
    logic [PHASE_BITS-1:0]        phase_hi;
    logic [TABLE_ADDR_BITS-1:0]   len_mask;
    logic [TABLE_ADDR_BITS-1:0]   idx;
    logic [TABLE_ADDR_BITS-1:0]   nxt;
    logic [PHASE_BITS-2:0]        frac;
    logic                         s1_tick;

    assign scale_prod = SCALE_PROD_BITS'(in_freq) * SCALE_PROD_BITS'(step_scale);

    // saturate table size to 1 .. TABLE_ADDR_BITS
    always_comb
    begin
        priority if (size_log2 == '0)
        begin
            sl = SLW'(1);
        end
        else if (int'(size_log2) > TABLE_ADDR_BITS)
        begin
            sl = SLW'(TABLE_ADDR_BITS);
        end
        else
        begin
            sl = SLW'(size_log2);
        end
    end

    assign lobits   = LW'(PHASE_BITS - int'(sl));
    assign phase_hi = phase_reg >> lobits;
    assign len_mask = ~({TABLE_ADDR_BITS{1'b1}} << sl);
    assign idx      = phase_hi[TABLE_ADDR_BITS-1:0] & len_mask;
    assign nxt      = (idx + 1'b1) & len_mask;
    assign frac     = phase_reg[PHASE_BITS-2:0] & ~({(PHASE_BITS-1){1'b1}} << lobits);

    assign s1_tick    = s1_ctl_reg.valid && (s1_ctl_reg.func == FUNC_TICK);
    assign phase_next = phase_reg + s1_inc_reg;

    // table writes happen in the same stage as the reads, so order is kept
    assign ram_we    = advance && s1_ctl_reg.valid && (s1_ctl_reg.func == FUNC_WRITE);
    assign ram_waddr = s1_addr_reg;
    assign ram_wdata = s1_data_reg;
    assign ram_re    = advance;
    assign rd_addr0  = idx;
    assign rd_addr1  = nxt;

    assign s2_ctl    = s2_ctl_reg;
    assign s2_frac   = s2_frac_reg;
    assign s2_lobits = s2_lobits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '{valid: 1'b0, func: FUNC_TICK};
            s2_ctl_reg <= '{valid: 1'b0, func: FUNC_TICK};
            phase_reg  <= '0;
        end
        else if (advance)
        begin
            s1_ctl_reg <= '{valid: in_valid, func: in_func};
            s2_ctl_reg <= s1_ctl_reg;
            if (s1_tick)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_inc_reg    <= scale_prod[SCALE_REF-PHASE_BITS +: PHASE_BITS];
            s1_addr_reg   <= in_addr;
            s1_data_reg   <= in_data;
            s2_frac_reg   <= frac;
            s2_lobits_reg <= lobits;
        end
    end

    a_phase_moves_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |-> $past(advance && s1_tick))
        else $error("phase changed without a tick leaving stage 1");

    a_stall_holds_s2: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s2_ctl_reg) && $stable(phase_reg))
        else $error("stage 2 or phase moved during a stall");

    a_no_write_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s1_tick ##1 $stable(phase_reg))
        else $error("table write overlapped a tick in stage 1");

endmodule

// ----- hdl/wti_interp.sv -----
// ============================================================================
// wti_interp
// Linear interpolation between two adjacent table entries.
// ============================================================================
module wti_interp
    import wti_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  stage_ctl_t                    s2_ctl,
    input  logic [PHASE_BITS-2:0]         s2_frac,
    input  logic [$clog2(PHASE_BITS)-1:0] s2_lobits,
    input  logic [SAMPLE_BITS-1:0]        v0,
    input  logic [SAMPLE_BITS-1:0]        v1,
    output stage_ctl_t                    res_ctl,
    output logic [SAMPLE_BITS-1:0]        res_sample
);

    localparam int LW = $clog2(PHASE_BITS);
    localparam int PW = SAMPLE_BITS + PHASE_BITS + 1;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PHASE_BITS-1:0]  frac_s;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          shifted;

    stage_ctl_t                    s3_ctl_reg;
    logic signed [PW-1:0]          s3_prod_reg;
    logic [SAMPLE_BITS-1:0]        s3_v0_reg;
    logic [LW-1:0]                 s3_lobits_reg;

    assign diff   = $signed({v1[SAMPLE_BITS-1], v1}) - $signed({v0[SAMPLE_BITS-1], v0});
    assign frac_s = $signed({1'b0, s2_frac});
    assign prod   = diff * frac_s;

    // arithmetic shift floors toward minus infinity
    assign shifted    = s3_prod_reg >>> s3_lobits_reg;
    assign res_sample = s3_v0_reg + shifted[SAMPLE_BITS-1:0];
    assign res_ctl    = s3_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '{valid: 1'b0, func: FUNC_TICK};
        end
        else if (advance)
        begin
            s3_ctl_reg <= s2_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_prod_reg   <= prod;
            s3_v0_reg     <= v0;
            s3_lobits_reg <= s2_lobits;
        end
    end

endmodule

// ----- hdl/wavetable_oscillator_interp.sv -----
// A tick item accepted into stage 1 passes the table read, the interpolation
//   product and the shift/add into the output register before its sample shows
//   on m_tvalid; the increment multiply lands in stage 1 at acceptance.
// Throughput: one item per cycle, ticks and table writes alike, with no hazard
//   between them; only a held result (m_tready low) stalls the whole pipeline.
// Reset clears the phase, the pipeline valids and the config registers to defaults;
//   table contents are undefined until written.
// ============================================================================
// wavetable_oscillator_interp
// DDS oscillator: phase accumulator over a power-of-two wave table with
// linear interpolation; table held in two mirrored RAMs for the entry pair.
// ============================================================================
module wavetable_oscillator_interp
    import wti_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_BITS      = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // freq_q8, table_address, table_data, zero fill
    input  logic [((FREQ_BITS + TABLE_ADDR_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // func
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sample, zero fill
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]           cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH = 1 << TABLE_ADDR_BITS;
    localparam int LW    = $clog2(PHASE_BITS);

    logic [SIZE_BITS-1:0]       size_log2_reg;
    logic [CFG_DATA_BITS-1:0]   step_scale_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_BITS-1:0]     out_sample_reg;

    logic                       advance;
    logic                       ram_we;
    logic [TABLE_ADDR_BITS-1:0] ram_waddr;
    logic [SAMPLE_BITS-1:0]     ram_wdata;
    logic                       ram_re;
    logic [TABLE_ADDR_BITS-1:0] rd_addr0;
    logic [TABLE_ADDR_BITS-1:0] rd_addr1;
    logic [SAMPLE_BITS-1:0]     v0;
    logic [SAMPLE_BITS-1:0]     v1;
    stage_ctl_t                 s2_ctl;
    logic [PHASE_BITS-2:0]      s2_frac;
    logic [LW-1:0]              s2_lobits;
    stage_ctl_t                 res_ctl;
    logic [SAMPLE_BITS-1:0]     res_sample;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg  <= SIZE_LOG2_RESET;
            step_scale_reg <= STEP_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SIZE_LOG2:  size_log2_reg  <= cfg_data[SIZE_BITS-1:0];
                CFG_STEP_SCALE: step_scale_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    wti_phase #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (s_tvalid),
        .in_func    (func_t'(s_tuser[0])),
        .in_freq    (s_tdata[FREQ_BITS-1:0]),
        .in_addr    (s_tdata[FREQ_BITS +: TABLE_ADDR_BITS]),
        .in_data    (s_tdata[FREQ_BITS + TABLE_ADDR_BITS +: SAMPLE_BITS]),
        .size_log2  (size_log2_reg),
        .step_scale (step_scale_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .rd_addr0   (rd_addr0),
        .rd_addr1   (rd_addr1),
        .s2_ctl     (s2_ctl),
        .s2_frac    (s2_frac),
        .s2_lobits  (s2_lobits)
    );

    // two copies of the table, written together, read at idx and idx+1
    wti_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr0),
        .rdata (v0)
    );

    wti_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr1),
        .rdata (v1)
    );

    wti_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s2_ctl     (s2_ctl),
        .s2_frac    (s2_frac),
        .s2_lobits  (s2_lobits),
        .v0         (v0),
        .v1         (v1),
        .res_ctl    (res_ctl),
        .res_sample (res_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_ctl.valid && (res_ctl.func == FUNC_TICK);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= res_sample;
        end
    end

    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(res_ctl.valid && (res_ctl.func == FUNC_TICK)))
        else $error("result raised without a tick in the last stage");

    a_write_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_ctl.valid && (res_ctl.func == FUNC_WRITE)) |=> !out_valid_reg)
        else $error("table write item produced a result");

    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_ctl.valid && (res_ctl.func == FUNC_TICK)) |=> out_valid_reg)
        else $error("tick item lost at the result register");

    a_write_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ram_re)
        else $error("table written while the read side was stalled");

endmodule
